// ----- rtl/fractal_gradient_noise_3d_core_macros.svh -----
// assertion macros for the fractal gradient noise core
// used by rtl/fractal_gradient_noise_3d_core.sv, no other dependencies
`ifndef FRACTAL_GRADIENT_NOISE_3D_CORE_MACROS_SVH
`define FRACTAL_GRADIENT_NOISE_3D_CORE_MACROS_SVH

// same-cycle implication
`define FGN_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FGN_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fgn_pkg.sv -----
// shared constants, types and functions for the fractal gradient noise core
// no dependencies; used by fgn_div and fractal_gradient_noise_3d_core
package fgn_pkg;

   localparam int MAX_OCTAVES     = 12;
   localparam int COORD_FRAC_BITS = 16;

   localparam int POS_W    = 32 + COORD_FRAC_BITS;
   localparam int MAG_LO_W = 24;
   localparam int OP_W     = 33;
   localparam int PROD_W   = 2 * OP_W;
   localparam int TLO_W    = OP_W;
   localparam int R_W      = POS_W + 9;
   localparam int S_W      = 21;
   localparam int U_W      = 18;
   localparam int FADE_W   = 17;
   localparam int V_W      = 20;
   localparam int DIF_W    = V_W + 1;
   localparam int DOT_W    = 20;
   localparam int OFS_W    = 18;
   localparam int WGT_W    = 17;
   localparam int OCT_W    = $clog2(MAX_OCTAVES + 1);
   localparam int NORM_W   = $clog2(MAX_OCTAVES * 65536 + 1);
   localparam int DEN_W    = NORM_W + 1;
   localparam int ACC_W    = 40;
   localparam int NUM_W    = ACC_W + 1;
   localparam int DCNT_W   = $clog2(NUM_W);
   localparam int CSR_IDX_W = 4;

   localparam logic [31:0] HASH_CX   = 32'h8da6b343;
   localparam logic [31:0] HASH_CY   = 32'hd8163841;
   localparam logic [31:0] HASH_CZ   = 32'hcb1ab31f;
   localparam logic [31:0] HASH_CS   = 32'h165667b1;
   localparam logic [31:0] HASH_M1   = 32'h7feb352d;
   localparam logic [31:0] HASH_M2   = 32'h846ca68b;
   localparam logic [31:0] RECIP_3   = 32'haaaaaaab;
   localparam logic [31:0] INV_SQRT2 = 32'd46341;
   localparam logic [31:0] ONE_Q8_24 = 32'h0100_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SEED     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FREQUENCY = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_LACUNARITY     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE    = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X       = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y       = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z       = CSR_IDX_W'(7);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEED,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_FADE1,
      ST_FADE2,
      ST_FADE3,
      ST_FADE4,
      ST_HASH1,
      ST_HASH2,
      ST_HASH3,
      ST_HASH4,
      ST_HASH5,
      ST_HASH6,
      ST_HASH7,
      ST_LERP,
      ST_ACC,
      ST_WGT,
      ST_DIV
   } st_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

   // round a Q16 product: add one half, then floor
   function automatic logic signed [PROD_W-1:0] rq16(input logic signed [PROD_W-1:0] p);
      rq16 = (p + PROD_W'(32768)) >>> 16;
   endfunction

   // dot product of an edge gradient with the corner offset
   function automatic logic signed [DOT_W-1:0] grad_dot(input logic [3:0] g,
                                                       input logic signed [OFS_W-1:0] ox,
                                                       input logic signed [OFS_W-1:0] oy,
                                                       input logic signed [OFS_W-1:0] oz);
      logic signed [DOT_W-1:0] x;
      logic signed [DOT_W-1:0] y;
      logic signed [DOT_W-1:0] z;
      x = DOT_W'(ox);
      y = DOT_W'(oy);
      z = DOT_W'(oz);
      case (g)
         4'd0:    grad_dot = x + y;
         4'd1:    grad_dot = y - x;
         4'd2:    grad_dot = x - y;
         4'd3:    grad_dot = -x - y;
         4'd4:    grad_dot = x + z;
         4'd5:    grad_dot = z - x;
         4'd6:    grad_dot = x - z;
         4'd7:    grad_dot = -x - z;
         4'd8:    grad_dot = y + z;
         4'd9:    grad_dot = z - y;
         4'd10:   grad_dot = y - z;
         4'd11:   grad_dot = -y - z;
         default: grad_dot = '0;
      endcase
   endfunction

endpackage

// ----- rtl/fractal_gradient_noise_3d_core.sv -----
// fractal 3d gradient noise core: top level with sequencer and shared multiplier
// depends on fgn_pkg, fgn_div and fractal_gradient_noise_3d_core_macros.svh
//
// usage:
//   configuration: csr_valid/csr_ready write channel, csr_index selects the
//   register, csr_data carries the value; csr_ready is always high; the user
//   must write only while the core is idle, which the core does not enforce;
//   unknown indexes are dropped; request: a transaction is taken when start is
//   high and busy is low; req_pos_x/y/z are sampled at that edge and busy stays high until done
//   response: rsp_valid pulses for one cycle with rsp_noise_value; there is
//   no back-pressure, the receiver takes it in that cycle
//   operation: one transaction at a time, done on the single 33x33
//   multiplier, with eight hashed corners of seven products each per
//   octave, and a 41-step
//   bit-serial divider at the end
//   reset: synchronous, active high; returns to idle with the registers at
//   seed 0, frequency 1.0, one octave, lacunarity 2.0, persistence 0.5 and
//   zero offsets
module fractal_gradient_noise_3d_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [31:0]             req_pos_x,
   input  logic signed [31:0]             req_pos_y,
   input  logic signed [31:0]             req_pos_z,
   output logic                           rsp_valid,
   output logic signed [15:0]             rsp_noise_value,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fgn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data
);
   import fgn_pkg::*;

   `include "fractal_gradient_noise_3d_core_macros.svh"

   // configuration registers
   logic [31:0]        seed_ff, seed_in;
   logic [31:0]        freq_ff, freq_in;
   logic [3:0]         octn_ff, octn_in;
   logic [27:0]        lac_ff, lac_in;
   logic [16:0]        pers_ff, pers_in;
   logic signed [31:0] off_x_ff, off_x_in;
   logic signed [31:0] off_y_ff, off_y_in;
   logic signed [31:0] off_z_ff, off_z_in;

   // sequencer
   st_type             state_ff, state_in;
   logic               ph_ff, ph_in;
   logic [1:0]         ax_ff, ax_in;
   logic [2:0]         cn_ff, cn_in;
   logic [2:0]         lp_ff, lp_in;
   logic [OCT_W-1:0]   oct_ff, oct_in;
   logic               scl_lac_ff, scl_lac_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [POS_W-1:0]  pos_in [3];
   logic [FADE_W-1:0]        fade_ff [3];
   logic [FADE_W-1:0]        fade_in [3];
   logic signed [V_W-1:0]    v_ff [8];
   logic signed [V_W-1:0]    v_in [8];
   logic [TLO_W-1:0]         tlo_ff, tlo_in;
   logic signed [S_W-1:0]    s_ff, s_in;
   logic signed [U_W-1:0]    u_ff, u_in;
   logic [31:0]              sh_ff, sh_in;
   logic [31:0]              h_ff, h_in;
   logic [3:0]               g_ff, g_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [NORM_W-1:0]        norm_ff, norm_in;
   logic [WGT_W-1:0]         weight_ff, weight_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [15:0]       noise_ff, noise_in;

   // shared multiplier operands
   logic signed [OP_W-1:0]   mul_a, mul_b;

   // derived values
   logic [31:0]              freq_eff;
   logic [27:0]              lac_eff;
   logic [WGT_W-1:0]         pers_eff;
   logic [OCT_W-1:0]         n_eff;
   logic [31:0]              k_sel;
   logic signed [POS_W-1:0]  cur_pos;
   logic                     cur_neg;
   logic [POS_W-1:0]         mag;
   logic [PROD_W-1:0]        prod_u;
   logic signed [PROD_W-1:0] rq;
   logic [R_W-1:0]           r_sum, r_sat, lim;
   logic [31:0]              lattice [3];
   logic [15:0]              frac [3];
   logic signed [OFS_W-1:0]  ofs [3];
   logic signed [OP_W-1:0]   t_s;
   logic [31:0]              hx, hy, hz;
   logic [31:0]              hh3, hh4, hh5;
   logic [28:0]              q12;
   logic [31:0]              rem12;
   logic signed [DOT_W-1:0]  dot;
   logic [FADE_W-1:0]        fade_sel;
   logic signed [DIF_W-1:0]  diff;
   logic signed [V_W-1:0]    v_push;
   logic [ACC_W-1:0]         acc_mag;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   assign csr_ready       = 1'b1;
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = noise_ff;

   assign freq_eff = (freq_ff == 32'd0) ? 32'd1 : freq_ff;
   assign lac_eff  = (lac_ff < 28'(ONE_Q8_24)) ? 28'(ONE_Q8_24) : lac_ff;
   assign pers_eff = (pers_ff > 17'd65536) ? 17'd65536 : pers_ff;

   always_comb begin
      if (octn_ff == 4'd0) begin
         n_eff = OCT_W'(1);
      end else if (32'(octn_ff) > 32'(MAX_OCTAVES)) begin
         n_eff = OCT_W'(MAX_OCTAVES);
      end else begin
         n_eff = OCT_W'(octn_ff);
      end
   end

   // position split into lattice cell and q0.16 fraction
   for (genvar a = 0; a < 3; a++) begin : g_split
      assign lattice[a] = pos_ff[a][COORD_FRAC_BITS+31:COORD_FRAC_BITS];
      assign frac[a] = 16'({pos_ff[a][COORD_FRAC_BITS-1:0], 16'b0} >> COORD_FRAC_BITS);
      assign ofs[a]  = $signed({2'b00, frac[a]})
                     - (cn_ff[a] ? OFS_W'(65536) : OFS_W'(0));
   end

   assign k_sel   = scl_lac_ff ? {4'b0, lac_eff} : freq_eff;
   assign cur_pos = pos_ff[ax_ff];
   assign cur_neg = cur_pos[POS_W-1];
   assign mag     = cur_neg ? POS_W'(-cur_pos) : POS_W'(cur_pos);
   assign prod_u  = prod_ff;
   assign rq      = rq16(prod_ff);
   assign lim     = R_W'(1) << (POS_W - 1);
   assign r_sum   = R_W'(prod_u) + R_W'(tlo_ff);

   always_comb begin
      if (cur_neg) begin
         r_sat = (r_sum > lim) ? lim : r_sum;
      end else begin
         r_sat = (r_sum > lim - R_W'(1)) ? lim - R_W'(1) : r_sum;
      end
   end

   assign t_s = OP_W'(frac[ax_ff]);
   assign hx  = lattice[0] + 32'(cn_ff[0]);
   assign hy  = lattice[1] + 32'(cn_ff[1]);
   assign hz  = lattice[2] + 32'(cn_ff[2]);
   assign hh3 = h_ff ^ prod_u[31:0] ^ sh_ff;
   assign hh4 = prod_u[31:0];
   assign hh5 = prod_u[31:0];
   assign q12   = prod_u[63:35];
   assign rem12 = h_ff - ((32'(q12) << 3) + (32'(q12) << 2));
   assign dot   = grad_dot(g_ff, ofs[0], ofs[1], ofs[2]);

   assign fade_sel = (lp_ff < 3'd4) ? fade_ff[0] : ((lp_ff < 3'd6) ? fade_ff[1] : fade_ff[2]);
   assign diff     = DIF_W'(v_ff[1]) - DIF_W'(v_ff[0]);
   assign v_push   = v_ff[0] + V_W'(rq);
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   assign div_req.start = (state_ff == ST_DIV) && !ph_ff;
   assign div_req.num   = NUM_W'(acc_mag) + NUM_W'(norm_ff);
   assign div_req.den   = {norm_ff, 1'b0};

   fgn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration writes
   always_comb begin
      seed_in  = seed_ff;
      freq_in  = freq_ff;
      octn_in  = octn_ff;
      lac_in   = lac_ff;
      pers_in  = pers_ff;
      off_x_in = off_x_ff;
      off_y_in = off_y_ff;
      off_z_in = off_z_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NOISE_SEED:     seed_in  = csr_data;
            CSR_BASE_FREQUENCY: freq_in  = csr_data;
            CSR_OCTAVE_COUNT:   octn_in  = csr_data[3:0];
            CSR_LACUNARITY:     lac_in   = csr_data[27:0];
            CSR_PERSISTENCE:    pers_in  = csr_data[16:0];
            CSR_OFFSET_X:       off_x_in = $signed(csr_data);
            CSR_OFFSET_Y:       off_y_in = $signed(csr_data);
            CSR_OFFSET_Z:       off_z_in = $signed(csr_data);
            default: ;
         endcase
      end
   end

   // sequencer: each step but idle and the divide issues a product, then writes it back
   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      ax_in        = ax_ff;
      cn_in        = cn_ff;
      lp_in        = lp_ff;
      oct_in       = oct_ff;
      scl_lac_in   = scl_lac_ff;
      rsp_valid_in = 1'b0;
      pos_in       = pos_ff;
      fade_in      = fade_ff;
      v_in         = v_ff;
      tlo_in       = tlo_ff;
      s_in         = s_ff;
      u_in         = u_ff;
      sh_in        = sh_ff;
      h_in         = h_ff;
      g_in         = g_ff;
      acc_in       = acc_ff;
      norm_in      = norm_ff;
      weight_in    = weight_ff;
      noise_in     = noise_ff;
      mul_a        = '0;
      mul_b        = '0;
      if (state_ff != ST_IDLE && state_ff != ST_DIV) begin
         ph_in = !ph_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pos_in[0]  = POS_W'(req_pos_x) + POS_W'(off_x_ff);
               pos_in[1]  = POS_W'(req_pos_y) + POS_W'(off_y_ff);
               pos_in[2]  = POS_W'(req_pos_z) + POS_W'(off_z_ff);
               acc_in     = '0;
               norm_in    = '0;
               weight_in  = WGT_W'(65536);
               oct_in     = '0;
               scl_lac_in = 1'b0;
               ph_in      = 1'b0;
               ax_in      = 2'd0;
               state_in   = ST_SEED;
            end
         end
         ST_SEED: begin
            mul_a = OP_W'(seed_ff);
            mul_b = OP_W'(HASH_CS);
            if (ph_ff) begin
               sh_in    = prod_u[31:0];
               state_in = ST_SCALE_LO;
            end
         end
         ST_SCALE_LO: begin
            mul_a = OP_W'(mag[MAG_LO_W-1:0]);
            mul_b = OP_W'(k_sel);
            if (ph_ff) begin
               tlo_in   = TLO_W'((prod_u + (PROD_W'(1) << 23)) >> 24);
               state_in = ST_SCALE_HI;
            end
         end
         ST_SCALE_HI: begin
            mul_a = OP_W'(mag[POS_W-1:MAG_LO_W]);
            mul_b = OP_W'(k_sel);
            if (ph_ff) begin
               pos_in[ax_ff] = cur_neg ? -POS_W'(r_sat) : POS_W'(r_sat);
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  state_in = ST_FADE1;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_SCALE_LO;
               end
            end
         end
         ST_FADE1: begin
            mul_a = t_s;
            mul_b = (t_s <<< 2) + (t_s <<< 1) - OP_W'(983040);
            if (ph_ff) begin
               s_in     = S_W'(rq + PROD_W'(655360));
               state_in = ST_FADE2;
            end
         end
         ST_FADE2: begin
            mul_a = t_s;
            mul_b = t_s;
            if (ph_ff) begin
               u_in     = U_W'(rq);
               state_in = ST_FADE3;
            end
         end
         ST_FADE3: begin
            mul_a = OP_W'(u_ff);
            mul_b = t_s;
            if (ph_ff) begin
               u_in     = U_W'(rq);
               state_in = ST_FADE4;
            end
         end
         ST_FADE4: begin
            mul_a = OP_W'(u_ff);
            mul_b = OP_W'(s_ff);
            if (ph_ff) begin
               if (rq < 0) begin
                  fade_in[ax_ff] = '0;
               end else if (rq > 65536) begin
                  fade_in[ax_ff] = FADE_W'(65536);
               end else begin
                  fade_in[ax_ff] = rq[FADE_W-1:0];
               end
               if (ax_ff == 2'd2) begin
                  ax_in    = 2'd0;
                  cn_in    = 3'd0;
                  state_in = ST_HASH1;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_FADE1;
               end
            end
         end
         ST_HASH1: begin
            mul_a = OP_W'(hx);
            mul_b = OP_W'(HASH_CX);
            if (ph_ff) begin
               h_in     = prod_u[31:0];
               state_in = ST_HASH2;
            end
         end
         ST_HASH2: begin
            mul_a = OP_W'(hy);
            mul_b = OP_W'(HASH_CY);
            if (ph_ff) begin
               h_in     = h_ff ^ prod_u[31:0];
               state_in = ST_HASH3;
            end
         end
         ST_HASH3: begin
            mul_a = OP_W'(hz);
            mul_b = OP_W'(HASH_CZ);
            if (ph_ff) begin
               h_in     = hh3 ^ (hh3 >> 16);
               state_in = ST_HASH4;
            end
         end
         ST_HASH4: begin
            mul_a = OP_W'(h_ff);
            mul_b = OP_W'(HASH_M1);
            if (ph_ff) begin
               h_in     = hh4 ^ (hh4 >> 15);
               state_in = ST_HASH5;
            end
         end
         ST_HASH5: begin
            mul_a = OP_W'(h_ff);
            mul_b = OP_W'(HASH_M2);
            if (ph_ff) begin
               h_in     = hh5 ^ (hh5 >> 16);
               state_in = ST_HASH6;
            end
         end
         ST_HASH6: begin
            mul_a = OP_W'(h_ff);
            mul_b = OP_W'(RECIP_3);
            if (ph_ff) begin
               g_in     = rem12[3:0];
               state_in = ST_HASH7;
            end
         end
         ST_HASH7: begin
            mul_a = OP_W'(dot);
            mul_b = OP_W'(INV_SQRT2);
            if (ph_ff) begin
               v_in[cn_ff] = V_W'(rq);
               if (cn_ff == 3'd7) begin
                  lp_in    = 3'd0;
                  state_in = ST_LERP;
               end else begin
                  cn_in    = cn_ff + 3'd1;
                  state_in = ST_HASH1;
               end
            end
         end
         ST_LERP: begin
            mul_a = OP_W'(diff);
            mul_b = OP_W'(fade_sel);
            if (ph_ff) begin
               // pop two, push the blend
               for (int j = 0; j < 6; j++) begin
                  v_in[j] = v_ff[j+2];
               end
               v_in[3'd6 - lp_ff] = v_push;
               if (lp_ff == 3'd6) begin
                  state_in = ST_ACC;
               end else begin
                  lp_in = lp_ff + 3'd1;
               end
            end
         end
         ST_ACC: begin
            mul_a = OP_W'(v_ff[0]);
            mul_b = OP_W'(weight_ff);
            if (ph_ff) begin
               acc_in   = acc_ff + ACC_W'(prod_ff);
               norm_in  = norm_ff + NORM_W'(weight_ff);
               state_in = ST_WGT;
            end
         end
         ST_WGT: begin
            mul_a = OP_W'(weight_ff);
            mul_b = OP_W'(pers_eff);
            if (ph_ff) begin
               weight_in = WGT_W'(rq);
               oct_in    = oct_ff + OCT_W'(1);
               if (oct_ff == n_eff - OCT_W'(1)) begin
                  state_in = ST_DIV;
               end else begin
                  scl_lac_in = 1'b1;
                  ax_in      = 2'd0;
                  state_in   = ST_SCALE_LO;
               end
            end
         end
         ST_DIV: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (div_rsp.done) begin
               ph_in        = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (acc_ff[ACC_W-1]) begin
                  noise_in = (div_rsp.quo > NUM_W'(32768)) ? 16'sh8000
                                                           : -$signed(div_rsp.quo[15:0]);
               end else begin
                  noise_in = (div_rsp.quo > NUM_W'(32767)) ? 16'sh7fff
                                                           : $signed(div_rsp.quo[15:0]);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         freq_ff      <= ONE_Q8_24;
         octn_ff      <= 4'd1;
         lac_ff       <= 28'h200_0000;
         pers_ff      <= 17'd32768;
         off_x_ff     <= '0;
         off_y_ff     <= '0;
         off_z_ff     <= '0;
         state_ff     <= ST_IDLE;
         ph_ff        <= 1'b0;
         ax_ff        <= 2'd0;
         cn_ff        <= 3'd0;
         lp_ff        <= 3'd0;
         oct_ff       <= '0;
         scl_lac_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         freq_ff      <= freq_in;
         octn_ff      <= octn_in;
         lac_ff       <= lac_in;
         pers_ff      <= pers_in;
         off_x_ff     <= off_x_in;
         off_y_ff     <= off_y_in;
         off_z_ff     <= off_z_in;
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         ax_ff        <= ax_in;
         cn_ff        <= cn_in;
         lp_ff        <= lp_in;
         oct_ff       <= oct_in;
         scl_lac_ff   <= scl_lac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      fade_ff   <= fade_in;
      v_ff      <= v_in;
      tlo_ff    <= tlo_in;
      s_ff      <= s_in;
      u_ff      <= u_in;
      sh_ff     <= sh_in;
      h_ff      <= h_in;
      g_ff      <= g_in;
      acc_ff    <= acc_in;
      norm_ff   <= norm_in;
      weight_ff <= weight_in;
      noise_ff  <= noise_in;
      prod_ff   <= mul_a * mul_b;
   end

   `FGN_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy, "accepted transaction did not raise busy")
   `FGN_ASSERT_NXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "response strobe longer than one cycle")
   `FGN_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "response while sequencer still busy")
   `FGN_ASSERT_IMP(a_div_wait, clock, reset, div_rsp.done, state_ff == ST_DIV && ph_ff, "divider done outside of wait")

endmodule

// ----- rtl/fgn_div.sv -----
// bit-serial restoring divider for the final normalization
// depends on fgn_pkg (widths, request and response structs)
module fgn_div (
   input  logic                clock,
   input  logic                reset,
   input  fgn_pkg::div_req_type div_req,
   output fgn_pkg::div_rsp_type div_rsp
);
   import fgn_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  nq_ff, nq_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial;

   assign trial = {rem_ff, nq_ff[NUM_W-1]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         nq_in  = div_req.num;
         rem_in = '0;
         den_in = div_req.den;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            nq_in  = {nq_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            nq_in  = {nq_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DCNT_W'(1);
         if (cnt_ff == DCNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = nq_ff;

endmodule
